### rtl/swmf_pkg.sv
// Shared types and constants for the sliding window median filter.
// Used by the sorting cells, the sorting chain and the top level.
// No dependencies.
package swmf_pkg;

  // Default sizing handed to the top level parameters.
  localparam int MAX_HALF_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 24;

  // Configuration register file.
  localparam int         CFG_ADDR_W        = 3;
  localparam int         WIDTH_BITS        = 5;
  localparam logic [4:0] WIDTH_RESET       = 5'd5;
  localparam logic       REG_WINDOW_WIDTH  = 1'b0;

  // Command broadcast to every sorting cell.
  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } swmf_ctrl_t;

  // Status that a sorting cell hands to its neighbors.
  typedef struct packed {
    logic full;
    logic gt;   // empty, or holds a value greater than the broadcast one
  } swmf_cell_st_t;

endpackage

### rtl/swmf_sort_cell.sv
// One cell of the insertion sorting chain: holds one value and its occupancy.
// Depends on swmf_pkg for the command and status structs.
module swmf_sort_cell import swmf_pkg::*; #(
  parameter int W = SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  swmf_ctrl_t          ctrl,
  input  logic signed [W-1:0] x,
  input  logic signed [W-1:0] prev_val,
  input  swmf_cell_st_t       prev_st,
  input  logic signed [W-1:0] next_val,
  input  swmf_cell_st_t       next_st,
  output logic signed [W-1:0] val,
  output swmf_cell_st_t       st
);

  logic signed [W-1:0] val_r;
  logic                full_r;

  assign val     = val_r;
  assign st.full = full_r;
  assign st.gt   = !full_r || (val_r > x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (ctrl.clear) begin
      full_r <= 1'b0;
    end else if (ctrl.insert) begin
      if (prev_st.gt) begin
        full_r <= prev_st.full;
      end else if (st.gt) begin
        full_r <= 1'b1;
      end
    end else if (ctrl.shift) begin
      full_r <= next_st.full;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert && !ctrl.clear) begin
      // take the neighbor's value when the new one lands below us
      if (prev_st.gt) begin
        val_r <= prev_val;
      end else if (st.gt) begin
        val_r <= x;
      end
    end else if (ctrl.shift && !ctrl.clear) begin
      val_r <= next_val;
    end
  end

endmodule

### rtl/swmf_sort_chain.sv
// Row of sorting cells kept in ascending order, with an insert count.
// Depends on swmf_pkg and swmf_sort_cell.
module swmf_sort_chain import swmf_pkg::*; #(
  parameter int W     = SAMPLE_BITS_DEF,
  parameter int DEPTH = 2 * MAX_HALF_DEF + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  swmf_ctrl_t                   ctrl,
  input  logic signed [W-1:0]          x,
  output logic [$clog2(DEPTH+1)-1:0]   cnt,
  output logic signed [W-1:0]          head0,
  output logic signed [W-1:0]          head1
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic signed [W-1:0] cval [DEPTH];
  swmf_cell_st_t       cst  [DEPTH];
  logic [CNT_W-1:0]    cnt_r;

  localparam swmf_cell_st_t ST_LOW   = '{full: 1'b1, gt: 1'b0};
  localparam swmf_cell_st_t ST_EMPTY = '{full: 1'b0, gt: 1'b1};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [W-1:0] pv, nv;
    swmf_cell_st_t       ps, ns;

    if (i == 0) begin : g_first
      assign pv = '0;
      assign ps = ST_LOW;
    end else begin : g_mid
      assign pv = cval[i-1];
      assign ps = cst[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign nv = '0;
      assign ns = ST_EMPTY;
    end else begin : g_body
      assign nv = cval[i+1];
      assign ns = cst[i+1];
    end

    swmf_sort_cell #(.W(W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .x        (x),
      .prev_val (pv),
      .prev_st  (ps),
      .next_val (nv),
      .next_st  (ns),
      .val      (cval[i]),
      .st       (cst[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctrl.clear) begin
      cnt_r <= '0;
    end else if (ctrl.insert) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign cnt   = cnt_r;
  assign head0 = cval[0];
  assign head1 = cval[1];

endmodule

### rtl/swmf_window_line.sv
// Shift line of recent samples with their valid flags, newest at entry zero.
// One registered read port; no package dependency.
module swmf_window_line #(
  parameter int W     = 24,
  parameter int DEPTH = 17
) (
  input  logic                       clk,
  input  logic                       shift_en,
  input  logic signed [W-1:0]        din_val,
  input  logic                       din_ok,
  input  logic [$clog2(DEPTH)-1:0]   rd_idx,
  output logic signed [W-1:0]        rd_val,
  output logic                       rd_ok
);

  logic signed [W-1:0] val_q [DEPTH];
  logic                ok_q  [DEPTH];
  logic signed [W-1:0] rd_val_r;
  logic                rd_ok_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      val_q[0] <= din_val;
      ok_q[0]  <= din_ok;
      for (int k = 1; k < DEPTH; k++) begin
        val_q[k] <= val_q[k-1];
        ok_q[k]  <= ok_q[k-1];
      end
    end
    rd_val_r <= val_q[rd_idx];
    rd_ok_r  <= ok_q[rd_idx];
  end

  assign rd_val = rd_val_r;
  assign rd_ok  = rd_ok_r;

endmodule

### rtl/sliding_window_median_filter_unit.sv
// Sliding window median filter, top level.
// Depends on swmf_pkg, swmf_window_line, swmf_sort_chain and swmf_sort_cell.
//
// Centered running median over a stream of signed samples, each carrying a
// valid flag that stands in for NaN. With h = window_width/2 (capped at
// MAX_HALF), the result for a stream position is twice the median of the
// valid samples within +/- h positions, cut at the stream ends; an even
// count gives the sum of the two middle values, so the result is exact in
// half-LSB units. An invalid sample gives an invalid result with data zero.
// Widths of 0 or 1 pass samples through (doubled). Results lag the input by
// h transactions; the transaction marked tlast flushes every pending result,
// the final one carrying tlast, and the next transaction starts a new stream.
// Timing: a transaction is taken only while the block is idle. Each result
// then passes the states S_START, S_FEED, S_DRAIN, S_SHIFT and S_RESULT; in
// S_FEED the E window entries (at most 2*MAX_HALF+1) are fed one per cycle
// from the single read port of the window line into the sorting chain, and
// S_SHIFT makes S shifts (at most MAX_HALF) that bring the middle of the
// sorted chain to its head. A transaction that yields no result leaves the
// block idle. The result sits in an output register, so the next transaction
// is taken while it waits. window_width is written over the APB-style port at
// byte address 0; write it only while the block is idle.
module sliding_window_median_filter_unit import swmf_pkg::*; #(
  parameter int MAX_HALF    = MAX_HALF_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,   // sample
  input  logic                                 in_tuser,   // sample_valid
  input  logic                                 in_tlast,   // last
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((SAMPLE_BITS+8)/8)*8-1:0]     out_tdata,  // median_half_lsb
  output logic                                 out_tuser,  // median_valid
  output logic                                 out_tlast,  // last_out
  // configuration
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]                cfg_paddr,
  input  logic [31:0]                          cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int DEPTH   = 2 * MAX_HALF + 1;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int HALF_W  = $clog2(MAX_HALF + 1);
  localparam int OUT_W   = SAMPLE_BITS + 1;
  localparam int OTD_W   = ((SAMPLE_BITS + 8) / 8) * 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_FEED,
    S_DRAIN,
    S_SHIFT,
    S_RESULT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [WIDTH_BITS-1:0]    width_r, width_nxt;
  logic [CNT_W-1:0]         n_r, n_nxt;        // stream position
  logic [CNT_W-1:0]         nj_r, nj_nxt;      // stream position seen by the job
  logic [HALF_W-1:0]        h_r, h_nxt;
  logic [IDX_W-1:0]         c_r, c_nxt;        // center of the current result
  logic                     last_r, last_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [IDX_W-1:0]         hi_r, hi_nxt;
  logic                     feed_v_r, feed_v_nxt;
  logic                     feed_ctr_r, feed_ctr_nxt;
  logic                     ctr_ok_r, ctr_ok_nxt;
  logic [CNT_W-1:0]         shf_r, shf_nxt;
  logic                     out_tvalid_r, out_tvalid_nxt;
  logic signed [OUT_W-1:0]  out_data_r, out_data_nxt;
  logic                     out_ok_r, out_ok_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     in_acc;
  logic                     cfg_wr;
  logic [HALF_W-1:0]        h_cur;
  logic [CNT_W-1:0]         n_inc;
  logic [IDX_W-1:0]         n_inc_m1;
  logic [IDX_W-1:0]         lo_c, hi_c, sum_c, nj_m1;
  logic [IDX_W-1:0]         h_idx;
  logic [CNT_W-1:0]         cnt, shf_target, cnt_half;
  logic signed [SAMPLE_BITS-1:0] head0, head1, rd_val;
  logic                     rd_ok;
  logic signed [OUT_W-1:0]  median;
  logic                     out_free;
  swmf_ctrl_t               ctrl;

  // ---------------------------------------------------------------- ports
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OTD_W'(unsigned'(out_data_r));
  assign out_tuser  = out_ok_r;
  assign out_tlast  = out_last_r;
  assign out_free   = !out_tvalid_r || out_tready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_WINDOW_WIDTH) ? 32'(width_r) : '0;

  // ------------------------------------------------------- window geometry
  // Half width from the register, capped at the line's reach.
  always_comb begin
    if (32'(width_r[WIDTH_BITS-1:1]) > MAX_HALF) begin
      h_cur = HALF_W'(MAX_HALF);
    end else begin
      h_cur = HALF_W'(width_r[WIDTH_BITS-1:1]);
    end
  end

  assign n_inc    = (n_r == CNT_W'(DEPTH)) ? n_r : n_r + CNT_W'(1);
  assign n_inc_m1 = IDX_W'(n_inc - CNT_W'(1));

  // Window bounds of the current center: [max(0,c-h), min(c+h, n-1)].
  assign h_idx = IDX_W'(h_r);
  assign lo_c  = (c_r >= h_idx) ? c_r - h_idx : '0;
  assign sum_c = c_r + h_idx;
  assign nj_m1 = IDX_W'(nj_r - CNT_W'(1));
  assign hi_c  = (sum_c > nj_m1) ? nj_m1 : sum_c;

  // Shifts that bring the lower middle element to the head of the chain.
  assign cnt_half = cnt >> 1;
  always_comb begin
    if (cnt[0]) begin
      shf_target = cnt_half;
    end else if (cnt == '0) begin
      shf_target = '0;
    end else begin
      shf_target = cnt_half - CNT_W'(1);
    end
  end

  // Doubled median from the head of the chain; zero for an invalid center.
  always_comb begin
    if (!ctr_ok_r) begin
      median = '0;
    end else if (cnt[0]) begin
      median = {head0, 1'b0};
    end else begin
      median = OUT_W'(head0) + OUT_W'(head1);
    end
  end

  // ---------------------------------------------------------- datapath
  assign ctrl.clear  = (state_r == S_START);
  assign ctrl.insert = feed_v_r && rd_ok;
  assign ctrl.shift  = (state_r == S_SHIFT) && (shf_r != shf_target);

  swmf_window_line #(
    .W     (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_line (
    .clk      (clk),
    .shift_en (in_acc),
    .din_val  (signed'(in_tdata[SAMPLE_BITS-1:0])),
    .din_ok   (in_tuser),
    .rd_idx   (idx_r),
    .rd_val   (rd_val),
    .rd_ok    (rd_ok)
  );

  swmf_sort_chain #(
    .W     (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .x     (rd_val),
    .cnt   (cnt),
    .head0 (head0),
    .head1 (head1)
  );

  // ------------------------------------------------------------ control
  always_comb begin
    state_nxt      = state_r;
    width_nxt      = width_r;
    n_nxt          = n_r;
    nj_nxt         = nj_r;
    h_nxt          = h_r;
    c_nxt          = c_r;
    last_nxt       = last_r;
    idx_nxt        = idx_r;
    hi_nxt         = hi_r;
    feed_v_nxt     = 1'b0;
    feed_ctr_nxt   = 1'b0;
    ctr_ok_nxt     = ctr_ok_r;
    shf_nxt        = shf_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_ok_nxt     = out_ok_r;
    out_last_nxt   = out_last_r;

    if (cfg_wr && (cfg_paddr[2] == REG_WINDOW_WIDTH)) begin
      width_nxt = cfg_pwdata[WIDTH_BITS-1:0];
    end

    // capture the center's own valid flag as it streams past
    if (feed_v_r && feed_ctr_r) begin
      ctr_ok_nxt = rd_ok;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          h_nxt    = h_cur;
          nj_nxt   = n_inc;
          last_nxt = in_tlast;
          if (in_tlast) begin
            // flush: start at the oldest pending center, end at the newest sample
            n_nxt     = '0;
            c_nxt     = (32'(n_inc_m1) < 32'(h_cur)) ? n_inc_m1 : IDX_W'(h_cur);
            state_nxt = S_START;
          end else begin
            n_nxt = n_inc;
            c_nxt = IDX_W'(h_cur);
            if (32'(n_inc) > 32'(h_cur)) begin
              state_nxt = S_START;
            end
          end
        end
      end
      S_START: begin
        idx_nxt    = lo_c;
        hi_nxt     = hi_c;
        shf_nxt    = '0;
        ctr_ok_nxt = 1'b0;
        state_nxt  = S_FEED;
      end
      S_FEED: begin
        feed_v_nxt   = 1'b1;
        feed_ctr_nxt = (idx_r == c_r);
        if (idx_r == hi_r) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (shf_r == shf_target) begin
          state_nxt = S_RESULT;
        end else begin
          shf_nxt = shf_r + CNT_W'(1);
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = median;
          out_ok_nxt     = ctr_ok_r;
          out_last_nxt   = last_r && (c_r == '0);
          if (last_r && (c_r != '0)) begin
            c_nxt     = c_r - IDX_W'(1);
            state_nxt = S_START;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      width_r      <= WIDTH_RESET;
      n_r          <= '0;
      feed_v_r     <= 1'b0;
      feed_ctr_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      width_r      <= width_nxt;
      n_r          <= n_nxt;
      feed_v_r     <= feed_v_nxt;
      feed_ctr_r   <= feed_ctr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    nj_r       <= nj_nxt;
    h_r        <= h_nxt;
    c_r        <= c_nxt;
    last_r     <= last_nxt;
    idx_r      <= idx_nxt;
    hi_r       <= hi_nxt;
    ctr_ok_r   <= ctr_ok_nxt;
    shf_r      <= shf_nxt;
    out_data_r <= out_data_nxt;
    out_ok_r   <= out_ok_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
